// ===== rtl/core/hkrb_pkg.sv =====
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types, constants and the matrix keycode table of the keyboard
// report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

	localparam int ROM_COLS    = 13;
	localparam int ROM_ROWS    = 8;
	localparam int MATRIX_ROWS = 8;
	localparam int MATRIX_COLS = 13;
	localparam int ROW_LIMIT   = (MATRIX_ROWS < ROM_ROWS) ? MATRIX_ROWS : ROM_ROWS;
	localparam int COL_LIMIT   = (MATRIX_COLS < ROM_COLS) ? MATRIX_COLS : ROM_COLS;

	localparam int REPORT_KEYS = 6;

	localparam logic [7:0] ID_BYTE    = 8'h01;
	localparam logic [7:0] MOD_LOW    = 8'he0;
	localparam logic [7:0] MOD_HIGH   = 8'he7;
	localparam logic [7:0] EXTRA_LOW  = 8'hf0;
	localparam logic [7:0] EXTRA_HIGH = 8'hf1;
	localparam logic [7:0] NO_KEY     = 8'h00;

	localparam logic CFG_BOOT_PROTOCOL = 1'b0;
	localparam logic CFG_EXTRA_ENABLE  = 1'b1;

	typedef logic [7:0] keycode_t;

	typedef struct packed {
		logic     start;
		logic     press;
		keycode_t code;
	} slot_cmd_t;

	typedef struct packed {
		logic done;
		logic changed;
	} slot_sts_t;

	localparam keycode_t KEY_ROM [ROM_COLS][ROM_ROWS] = '{
		'{8'h00, 8'h00, 8'he0, 8'he3, 8'he4, 8'hf0, 8'h00, 8'h00},
		'{8'he3, 8'h29, 8'h2b, 8'h35, 8'h04, 8'h1d, 8'h1e, 8'h14},
		'{8'h3a, 8'h3d, 8'h3c, 8'h3b, 8'h07, 8'h06, 8'h20, 8'h08},
		'{8'h05, 8'h0a, 8'h17, 8'h22, 8'h09, 8'h19, 8'h21, 8'h15},
		'{8'h43, 8'h40, 8'h3f, 8'h3e, 8'h16, 8'h1b, 8'h1f, 8'h1a},
		'{8'h87, 8'h00, 8'h30, 8'h00, 8'h0e, 8'h36, 8'h25, 8'h0c},
		'{8'h11, 8'h0b, 8'h1c, 8'h23, 8'h0d, 8'h10, 8'h24, 8'h18},
		'{8'h00, 8'h00, 8'h64, 8'h00, 8'h00, 8'he1, 8'h00, 8'he5},
		'{8'h2e, 8'h34, 8'h2f, 8'h2d, 8'h33, 8'h38, 8'h27, 8'h13},
		'{8'h00, 8'h42, 8'h41, 8'h68, 8'h0f, 8'h37, 8'h26, 8'h12},
		'{8'he6, 8'h00, 8'h89, 8'h00, 8'h31, 8'h00, 8'he2, 8'h00},
		'{8'h00, 8'h2a, 8'h00, 8'h31, 8'h28, 8'h2c, 8'h51, 8'h52},
		'{8'h00, 8'h8a, 8'h00, 8'h8b, 8'h00, 8'h00, 8'h4f, 8'h50}
	};

	function automatic keycode_t keycode_lookup(input logic [2:0] row, input logic [3:0] col);
		keycode_t code;
		code = NO_KEY;
		if (int'(row) < ROW_LIMIT && int'(col) < COL_LIMIT) begin
			code = KEY_ROM[col][row];
		end
		return code;
	endfunction

endpackage

// ===== rtl/core/hkrb_intf.sv =====
// ----------------------------------------------------------------------------
// hkrb_intf
// Valid/ready channels of the keyboard report builder: matrix events in,
// report beats out.
// ----------------------------------------------------------------------------
interface hkrb_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] matrix_row;
	logic [3:0] matrix_col;
	logic       pressed;

	modport source (output valid, output matrix_row, output matrix_col, output pressed,
		input ready);
	modport sink (input valid, input matrix_row, input matrix_col, input pressed,
		output ready);
endinterface

interface hkrb_report_if;
	logic       valid;
	logic       ready;
	logic       changed;
	logic [7:0] header_byte;
	logic [7:0] second_byte;
	logic [7:0] key_a;
	logic [7:0] key_b;
	logic [7:0] key_c;
	logic [7:0] key_d;
	logic [7:0] key_e;
	logic [7:0] key_f;
	logic [1:0] extra_bits;

	modport source (output valid, output changed, output header_byte, output second_byte,
		output key_a, output key_b, output key_c, output key_d, output key_e, output key_f,
		output extra_bits, input ready);
	modport sink (input valid, input changed, input header_byte, input second_byte,
		input key_a, input key_b, input key_c, input key_d, input key_e, input key_f,
		input extra_bits, output ready);
endinterface

// ===== rtl/core/hid_keyboard_report_builder.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder
// Six-key-rollover keyboard report builder driven by key matrix events.
// ----------------------------------------------------------------------------
// Usage:
//   evt  : one beat per matrix event (row, column, pressed). ready is high
//          only while no event is in work.
//   rpt  : one beat per event: changed flag, two header bytes, six key
//          slots and the extra bits field.
//   cfg  : cfg_we/cfg_idx/cfg_wdata write boot_protocol (0) and
//          extra_enable (1); write only while no event is in work.
// Flow: modifier, extra and ignored codes pass S_DECODE, S_HEADER and S_OUT
//   to the report register; key codes also pass S_SCAN, where the shared slot
//   comparator visits the slots in order, 1 to KEY_SLOTS of them.
// Ordering: the next event can be accepted the cycle after the report beat is
//   written; only one event is in work at a time.
// Reset: slots, modifiers, extra bits and header bytes clear to zero,
//   boot_protocol to 0, extra_enable to 1.
// Stall: the report register holds until taken; the next event is accepted
//   meanwhile and waits for the register before its beat is written.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder
	import hkrb_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic                 cfg_wdata,
	hkrb_event_if.sink           evt,
	hkrb_report_if.source        rpt
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_HEADER,
		S_OUT
	} state_t;

	state_t    state_q;
	keycode_t  code_q;
	logic      press_q;
	logic      boot_q;
	logic      extra_en_q;
	logic [7:0] mod_q;
	logic [1:0] extra_q;
	logic [7:0] hdr0_q;
	logic [7:0] hdr1_q;
	logic      chg_q;
	slot_cmd_t cmd_q;

	logic       rpt_valid_q;
	logic       rpt_changed_q;
	logic [7:0] rpt_hdr0_q;
	logic [7:0] rpt_hdr1_q;
	keycode_t   rpt_keys_q [REPORT_KEYS];
	logic [1:0] rpt_extra_q;

	slot_sts_t sts;
	keycode_t  keys [REPORT_KEYS];
	logic      is_zero;
	logic      is_mod;
	logic      is_extra;
	logic      rpt_free;

	assign is_zero  = (code_q == NO_KEY);
	assign is_mod   = (code_q >= MOD_LOW) && (code_q <= MOD_HIGH);
	assign is_extra = (code_q >= EXTRA_LOW) && (code_q <= EXTRA_HIGH);
	assign rpt_free = !rpt_valid_q || rpt.ready;

	hkrb_slot_engine #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_slots (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_q),
		.sts   (sts),
		.keys  (keys)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			code_q        <= NO_KEY;
			press_q       <= 1'b0;
			boot_q        <= 1'b0;
			extra_en_q    <= 1'b1;
			mod_q         <= '0;
			extra_q       <= '0;
			hdr0_q        <= '0;
			hdr1_q        <= '0;
			chg_q         <= 1'b0;
			cmd_q         <= '0;
			rpt_valid_q   <= 1'b0;
			rpt_changed_q <= 1'b0;
			rpt_hdr0_q    <= '0;
			rpt_hdr1_q    <= '0;
			for (int i = 0; i < REPORT_KEYS; i++) begin
				rpt_keys_q[i] <= NO_KEY;
			end
			rpt_extra_q   <= '0;
		end else begin
			cmd_q.start <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_BOOT_PROTOCOL: boot_q     <= cfg_wdata;
					CFG_EXTRA_ENABLE:  extra_en_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (rpt_valid_q && rpt.ready) begin
				rpt_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						code_q  <= keycode_lookup(evt.matrix_row, evt.matrix_col);
						press_q <= evt.pressed;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					chg_q   <= 1'b0;
					state_q <= S_HEADER;
					priority if (is_zero) begin
						chg_q <= 1'b0;
					end else if (is_extra) begin
						if (extra_en_q) begin
							extra_q[code_q[0]] <= press_q;
							chg_q              <= 1'b1;
						end
					end else if (is_mod) begin
						mod_q[code_q[2:0]] <= press_q;
						chg_q              <= 1'b1;
					end else begin
						cmd_q.start <= 1'b1;
						cmd_q.press <= press_q;
						cmd_q.code  <= code_q;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.done) begin
						chg_q   <= sts.changed;
						state_q <= S_HEADER;
					end
				end
				S_HEADER: begin
					if (chg_q) begin
						if (boot_q) begin
							hdr0_q <= mod_q;
							hdr1_q <= '0;
						end else begin
							hdr0_q <= ID_BYTE;
							hdr1_q <= mod_q;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rpt_free) begin
						rpt_valid_q   <= 1'b1;
						rpt_changed_q <= chg_q;
						rpt_hdr0_q    <= hdr0_q;
						rpt_hdr1_q    <= hdr1_q;
						for (int i = 0; i < REPORT_KEYS; i++) begin
							rpt_keys_q[i] <= keys[i];
						end
						rpt_extra_q   <= extra_en_q ? extra_q : 2'b00;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt.ready       = (state_q == S_IDLE);
	assign rpt.valid       = rpt_valid_q;
	assign rpt.changed     = rpt_changed_q;
	assign rpt.header_byte = rpt_hdr0_q;
	assign rpt.second_byte = rpt_hdr1_q;
	assign rpt.key_a       = rpt_keys_q[0];
	assign rpt.key_b       = rpt_keys_q[1];
	assign rpt.key_c       = rpt_keys_q[2];
	assign rpt.key_d       = rpt_keys_q[3];
	assign rpt.key_e       = rpt_keys_q[4];
	assign rpt.key_f       = rpt_keys_q[5];
	assign rpt.extra_bits  = rpt_extra_q;

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == S_SCAN)
		else $error("slot scan finished outside scan state");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("event accepted while previous one in work");

	a_id_header: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.changed && !boot_q |-> rpt.header_byte == ID_BYTE)
		else $error("report id header missing on changed report");

	a_boot_header: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.changed && boot_q |-> rpt.second_byte == 8'h00)
		else $error("boot header second byte not zero");

	a_extra_masked: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && !extra_en_q |-> rpt.extra_bits == 2'b00)
		else $error("extra bits shown while disabled");

endmodule

// ===== rtl/core/hkrb_slot_engine.sv =====
// ----------------------------------------------------------------------------
// hkrb_slot_engine
// Key slot array with a one-slot-per-cycle scan: inserts a code into the
// first free slot on press unless the scan meets the code first, clears its slot on release.
// ----------------------------------------------------------------------------
module hkrb_slot_engine
	import hkrb_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  slot_cmd_t cmd,
	output slot_sts_t sts,
	output keycode_t  keys [REPORT_KEYS]
);

	localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

	keycode_t         slot_q [KEY_SLOTS];
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             press_q;
	keycode_t         code_q;
	slot_sts_t        sts_q;

	keycode_t cur;
	logic     hit;
	logic     empty;

	assign cur   = slot_q[idx_q];
	assign hit   = (cur == code_q);
	assign empty = (cur == NO_KEY);
	assign sts   = sts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slot_q[i] <= NO_KEY;
			end
			idx_q   <= '0;
			busy_q  <= 1'b0;
			press_q <= 1'b0;
			code_q  <= NO_KEY;
			sts_q   <= '0;
		end else begin
			sts_q.done <= 1'b0;
			if (cmd.start) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
				press_q <= cmd.press;
				code_q  <= cmd.code;
			end else if (busy_q) begin
				priority if (press_q && hit) begin
					busy_q        <= 1'b0;
					sts_q.done    <= 1'b1;
					sts_q.changed <= 1'b0;
				end else if (press_q && empty) begin
					slot_q[idx_q] <= code_q;
					busy_q        <= 1'b0;
					sts_q.done    <= 1'b1;
					sts_q.changed <= 1'b1;
				end else if (!press_q && hit) begin
					slot_q[idx_q] <= NO_KEY;
					busy_q        <= 1'b0;
					sts_q.done    <= 1'b1;
					sts_q.changed <= 1'b1;
				end else if (idx_q == LAST_IDX) begin
					busy_q        <= 1'b0;
					sts_q.done    <= 1'b1;
					sts_q.changed <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	for (genvar g = 0; g < REPORT_KEYS; g++) begin : g_keys
		if (g < KEY_SLOTS) begin : g_used
			assign keys[g] = slot_q[g];
		end else begin : g_unused
			assign keys[g] = NO_KEY;
		end
	end

endmodule

// ===== tb/hid_keyboard_report_builder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_test
// Self-checking bench for the six-key-rollover keyboard report builder.
// Matrix events are driven on the event channel. A scoreboard keeps its own
// copy of the modifier, slot, extra and header state, predicts one report
// per accepted event and compares each report beat field by field. The run
// walks through all boot/extra register settings with directed corner cases
// and random typing sequences, with random stalls and one long back-pressure
// hold on the report side.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_test;
	import hkrb_pkg::*;

	localparam int SLOT_COUNT     = 6;
	localparam int PHASE_EVENTS   = 450;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic            changed;
		logic [7:0]      header;
		logic [7:0]      second;
		logic [5:0][7:0] keys;
		logic [1:0]      extra;
	} key_report_t;

	class key_report_scoreboard;
		logic        boot_mode;
		logic        extra_en;
		logic [7:0]  mods;
		keycode_t    slots [SLOT_COUNT];
		logic [1:0]  extra;
		logic [7:0]  hdr0;
		logic [7:0]  hdr1;
		key_report_t pending_reports[$];
		int          errors;
		int          checked;
		int          changes;

		function new();
			boot_mode = 1'b0;
			extra_en  = 1'b1;
			mods      = '0;
			extra     = '0;
			hdr0      = '0;
			hdr1      = '0;
			foreach (slots[i]) slots[i] = NO_KEY;
			errors  = 0;
			checked = 0;
			changes = 0;
		endfunction

		function void set_register(logic idx, logic val);
			if (idx == CFG_BOOT_PROTOCOL) begin
				boot_mode = val;
			end else begin
				extra_en = val;
			end
		endfunction

		function int pending_count();
			return pending_reports.size();
		endfunction

		// accepted event: advance the state and queue the report it causes
		function void note_event(logic [2:0] row, logic [3:0] col, logic press);
			keycode_t    code;
			logic [7:0]  mask;
			logic        chg;
			logic        stop;
			key_report_t r;
			code = NO_KEY;
			chg  = 1'b0;
			stop = 1'b0;
			if (int'(row) < ROW_LIMIT && int'(col) < COL_LIMIT) begin
				code = KEY_ROM[col][row];
			end
			if (code == NO_KEY) begin
				chg = 1'b0;
			end else if (code >= EXTRA_LOW && code <= EXTRA_HIGH) begin
				if (extra_en) begin
					mask  = 8'd1 << (code - EXTRA_LOW);
					extra = press ? (extra | mask[1:0]) : (extra & ~mask[1:0]);
					chg   = 1'b1;
				end
			end else if (code >= MOD_LOW && code <= MOD_HIGH) begin
				mask = 8'd1 << (code - MOD_LOW);
				mods = press ? (mods | mask) : (mods & ~mask);
				chg  = 1'b1;
			end else if (press) begin
				for (int i = 0; i < SLOT_COUNT && !stop; i++) begin
					if (slots[i] == code) begin
						stop = 1'b1;
					end else if (slots[i] == NO_KEY) begin
						slots[i] = code;
						chg      = 1'b1;
						stop     = 1'b1;
					end
				end
			end else begin
				for (int i = 0; i < SLOT_COUNT && !stop; i++) begin
					if (slots[i] == code) begin
						slots[i] = NO_KEY;
						chg      = 1'b1;
						stop     = 1'b1;
					end
				end
			end
			if (chg) begin
				hdr0 = boot_mode ? mods : ID_BYTE;
				hdr1 = boot_mode ? 8'h00 : mods;
			end
			r.changed = chg;
			r.header  = hdr0;
			r.second  = hdr1;
			for (int i = 0; i < SLOT_COUNT; i++) r.keys[i] = slots[i];
			r.extra = extra_en ? extra : 2'b00;
			pending_reports.push_back(r);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_report(key_report_t got);
			key_report_t want;
			if (pending_reports.size() == 0) begin
				report_mismatch("report beat with no event pending", 64'(got.keys), 64'd0);
			end else begin
				want = pending_reports.pop_front();
				checked++;
				if (want.changed) changes++;
				if (got.changed !== want.changed)
					report_mismatch("changed", 64'(got.changed), 64'(want.changed));
				if (got.header !== want.header)
					report_mismatch("header_byte", 64'(got.header), 64'(want.header));
				if (got.second !== want.second)
					report_mismatch("second_byte", 64'(got.second), 64'(want.second));
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (got.keys[i] !== want.keys[i])
						report_mismatch($sformatf("key slot %0d", i),
							64'(got.keys[i]), 64'(want.keys[i]));
				end
				if (got.extra !== want.extra)
					report_mismatch("extra_bits", 64'(got.extra), 64'(want.extra));
			end
		endtask

		task close_out();
			while (pending_reports.size() != 0) begin
				report_mismatch("report never delivered", 64'd0,
					64'(pending_reports[0].keys));
				void'(pending_reports.pop_front());
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic cfg_wdata;

	hkrb_event_if  evt_ch ();
	hkrb_report_if rpt_ch ();

	hid_keyboard_report_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.rpt       (rpt_ch)
	);

	key_report_scoreboard report_sb = new();

	bit         no_idle      = 1'b0;
	bit         hold_pending = 1'b0;
	int         events_sent  = 0;
	int         cfg_writes   = 0;
	int         quiet_cycles = 0;
	logic [6:0] key_positions[$];
	logic [6:0] held_keys[$];

	always #5 clk = ~clk;

	// monitor: event beats feed the predictor, report beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready)
				report_sb.note_event(evt_ch.matrix_row, evt_ch.matrix_col, evt_ch.pressed);
			if (rpt_ch.valid && rpt_ch.ready)
				report_sb.check_report({rpt_ch.changed, rpt_ch.header_byte, rpt_ch.second_byte,
					rpt_ch.key_f, rpt_ch.key_e, rpt_ch.key_d, rpt_ch.key_c, rpt_ch.key_b,
					rpt_ch.key_a, rpt_ch.extra_bits});
		end
	end

	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// report side: random stalls plus one long hold-off on request
	initial begin : report_sink
		int hold_left;
		hold_left = 0;
		rpt_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rpt_ch.ready <= 1'b0;
			end else begin
				rpt_ch.ready <= no_idle || ($urandom_range(99) >= 6);
			end
		end
	end

	task automatic send_event(input logic [2:0] row, input logic [3:0] col,
		input logic press);
		while (!no_idle && $urandom_range(99) < 6) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.matrix_row <= row;
		evt_ch.matrix_col <= col;
		evt_ch.pressed    <= press;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		events_sent++;
		@(negedge clk);
	endtask

	// waits for the block to drain, then writes one register
	task automatic write_register(input logic idx, input logic val);
		evt_ch.valid <= 1'b0;
		@(negedge clk);
		while (report_sb.pending_count() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		report_sb.set_register(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly press/release sequences over real keys, some raw noise
	task automatic random_event();
		logic [6:0] pos;
		int         k;
		if ($urandom_range(99) < 15) begin
			send_event(3'($urandom_range(7)), 4'($urandom_range(15)),
				1'($urandom_range(1)));
		end else if (held_keys.size() == 0 ||
			(held_keys.size() < 9 && $urandom_range(99) < 55)) begin
			pos = key_positions[$urandom_range(key_positions.size() - 1)];
			send_event(pos[6:4], pos[3:0], 1'b1);
			k = 0;
			foreach (held_keys[i]) if (held_keys[i] == pos) k = 1;
			if (k == 0) held_keys.push_back(pos);
		end else begin
			k   = $urandom_range(held_keys.size() - 1);
			pos = held_keys[k];
			held_keys.delete(k);
			send_event(pos[6:4], pos[3:0], 1'b0);
		end
	endtask

	initial begin : main
		logic boot_seq  [4];
		logic extra_seq [4];
		boot_seq  = '{1'b1, 1'b0, 1'b1, 1'b0};
		extra_seq = '{1'b0, 1'b1, 1'b1, 1'b0};
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = CFG_BOOT_PROTOCOL;
		cfg_wdata         = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.matrix_row = '0;
		evt_ch.matrix_col = '0;
		evt_ch.pressed    = 1'b0;
		for (int c = 0; c < ROM_COLS; c++) begin
			for (int r = 0; r < ROM_ROWS; r++) begin
				if (KEY_ROM[c][r] != NO_KEY) key_positions.push_back({r[2:0], c[3:0]});
			end
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: report-id header, extra field on
		send_event(3'd0, 4'd0, 1'b1);   // empty table entry
		send_event(3'd7, 4'd12, 1'b1);  // last real key
		send_event(3'd7, 4'd15, 1'b1);  // column off the table
		send_event(3'd7, 4'd13, 1'b0);
		send_event(3'd2, 4'd0, 1'b1);   // modifier
		send_event(3'd5, 4'd0, 1'b1);   // extra bit
		for (int r = 1; r <= 6; r++) send_event(r[2:0], 4'd1, 1'b1);  // fills, then full
		send_event(3'd7, 4'd12, 1'b1);  // repeat press
		send_event(3'd1, 4'd1, 1'b0);   // opens slot 1
		send_event(3'd7, 4'd12, 1'b0);  // opens slot 0
		send_event(3'd2, 4'd1, 1'b1);   // held in slot 2, lands in slot 0 again
		send_event(3'd6, 4'd1, 1'b0);   // not held
		send_event(3'd5, 4'd0, 1'b0);
		send_event(3'd2, 4'd0, 1'b0);
		send_event(3'd4, 4'd10, 1'b1);  // same code at two positions
		send_event(3'd3, 4'd11, 1'b1);

		write_register(CFG_BOOT_PROTOCOL, 1'b1);
		write_register(CFG_EXTRA_ENABLE, 1'b0);
		send_event(3'd5, 4'd0, 1'b1);   // extra code while disabled
		send_event(3'd2, 4'd0, 1'b1);
		send_event(3'd0, 4'd1, 1'b1);
		send_event(3'd2, 4'd0, 1'b0);
		send_event(3'd0, 4'd1, 1'b0);

		for (int p = 0; p < 4; p++) begin
			write_register(CFG_BOOT_PROTOCOL, boot_seq[p]);
			write_register(CFG_EXTRA_ENABLE, extra_seq[p]);
			if (p == 1) hold_pending = 1'b1;
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				no_idle = (p == 2) && (n >= PHASE_EVENTS / 3) && (n < 2 * PHASE_EVENTS / 3);
				random_event();
			end
			no_idle = 1'b0;
		end

		evt_ch.valid <= 1'b0;
		@(negedge clk);
		while (report_sb.pending_count() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		report_sb.close_out();

		$display("%0d key events over %0d register writes, all four header/extra settings",
			events_sent, cfg_writes);
		$display("%0d reports checked, %0d with a change, %0d mismatches",
			report_sb.checked, report_sb.changes, report_sb.errors);
		if (report_sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== hid_keyboard_report_builder.f =====
rtl/core/hkrb_pkg.sv
rtl/core/hkrb_intf.sv
rtl/core/hkrb_slot_engine.sv
rtl/core/hid_keyboard_report_builder.sv
tb/hid_keyboard_report_builder_test.sv
